>>> design/c2dzpc_pkg.sv
`timescale 1ns / 1ps

package c2dzpc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_KERNEL_DEF = 5;
    localparam int MAX_HEIGHT     = 4096;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int K_W        = 3;
    localparam int HALF_W     = 2;
    localparam int OFS_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int COEF_ALL_W = 256;
    localparam int PROD_W     = 17;
    localparam int FIFO_DEPTH = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_WORD_0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_WORD_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_WORD_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_WORD_3 = 3'd6;

    // Window placement of one result, shared by every cell
    typedef struct packed {
        logic [OFS_W-1:0]  d;   // column shift past the newest column
        logic [OFS_W-1:0]  e;   // row shift past the newest row
        logic [K_W-1:0]    k;   // effective kernel side
        logic [HALF_W-1:0] h;   // half kernel
    } t_job;

endpackage

>>> design/c2dzpc_cell.sv
`timescale 1ns / 1ps

// One column of the window: holds a pixel column, passes it on, and
// forms the partial sum of its column for the result under way.
module c2dzpc_cell #(
    parameter int MAX_KERNEL = c2dzpc_pkg::MAX_KERNEL_DEF,
    parameter int CELL_IDX   = 0,
    localparam int COLSUM_W  = c2dzpc_pkg::PROD_W + $clog2(MAX_KERNEL)
) (
    input  logic                                 i_clk,
    input  logic                                 i_shift,
    input  logic                                 i_clear,
    input  logic [MAX_KERNEL-1:0][7:0]           i_col,
    output logic [MAX_KERNEL-1:0][7:0]           o_col,
    input  c2dzpc_pkg::t_job                     i_job,
    input  logic [c2dzpc_pkg::COEF_ALL_W-1:0]    i_coef,
    output logic signed [COLSUM_W-1:0]           o_sum
);

    logic [MAX_KERNEL-1:0][7:0]                 r_col;
    logic [MAX_KERNEL-1:0][7:0]                 r_pix;
    logic [MAX_KERNEL-1:0][7:0]                 r_coef;
    logic [MAX_KERNEL-1:0][7:0]                 n_coef;
    logic signed [c2dzpc_pkg::PROD_W-1:0]       r_prod [MAX_KERNEL];
    logic signed [COLSUM_W-1:0]                 r_sum;
    logic signed [COLSUM_W-1:0]                 n_sum;
    logic signed [4:0]                          kj;
    logic                                       kj_ok;
    logic signed [4:0]                          ki [MAX_KERNEL];
    logic [4:0]                                 tap [MAX_KERNEL];

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= (i_clear && CELL_IDX != 0) ? '0 : i_col;
        end
    end

    assign o_col = r_col;

    // Tap that meets each stored pixel for this placement
    always_comb begin
        kj = $signed({2'b00, i_job.h, 1'b0}) - $signed({3'b000, i_job.d}) - 5'(CELL_IDX);
        kj_ok = (kj >= 0) && (kj < $signed({2'b00, i_job.k}));
        for (int b = 0; b < MAX_KERNEL; b++) begin
            ki[b] = $signed({2'b00, i_job.h, 1'b0}) - $signed({3'b000, i_job.e}) - 5'(b);
            tap[b] = 5'(ki[b][2:0]) * 5'(i_job.k) + 5'(kj[2:0]);
            if (kj_ok && ki[b] >= 0 && ki[b] < $signed({2'b00, i_job.k})) begin
                n_coef[b] = i_coef[{tap[b], 3'b000} +: 8];
            end else begin
                n_coef[b] = '0;
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int b = 0; b < MAX_KERNEL; b++) begin
            n_sum = n_sum + COLSUM_W'(r_prod[b]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix  <= r_col;
        r_coef <= n_coef;
        for (int b = 0; b < MAX_KERNEL; b++) begin
            r_prod[b] <= $signed({1'b0, r_pix[b]}) * $signed(r_coef[b]);
        end
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

>>> design/c2dzpc_lines.sv
`timescale 1ns / 1ps

// Line store: one bank per kept row, one write and one column read a cycle.
module c2dzpc_lines #(
    parameter int MAX_WIDTH  = c2dzpc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = c2dzpc_pkg::MAX_KERNEL_DEF,
    localparam int COL_W     = $clog2(MAX_WIDTH),
    localparam int SLOT_W    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [SLOT_W-1:0]           i_slot,
    input  logic [COL_W-1:0]            i_addr,
    input  logic [7:0]                  i_data,
    input  logic                        i_re,
    output logic [MAX_KERNEL-1:0][7:0]  o_data
);

    for (genvar g = 0; g < MAX_KERNEL; g++) begin : g_bank
        logic [7:0] mem [MAX_WIDTH];

        always_ff @(posedge i_clk) begin
            if (i_we && i_slot == SLOT_W'(g)) begin
                mem[i_addr] <= i_data;
            end
            if (i_re) begin
                o_data[g] <= mem[i_addr];
            end
        end
    end

endmodule

>>> design/c2dzpc_fifo.sv
`timescale 1ns / 1ps

// Result queue in front of the output channel.
module c2dzpc_fifo #(
    parameter int DATA_W = 31,
    parameter int DEPTH  = c2dzpc_pkg::FIFO_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);

endmodule

>>> design/conv2d_zero_pad_clamp_top.sv
`timescale 1ns / 1ps

// Streaming K-by-K filter over 8-bit raster pixels with zero padding,
// rounding half up and clamping to 0..255. In steady state the block takes one
// pixel a cycle. A pixel that completes n results (more than one only at the
// end of a row or on the last row, at most (h+1)*(h+1) with h = (K-1)/2)
// holds the input until all n are issued, since the window engine issues one
// result a cycle; results also wait for room in the 16-entry result queue. A
// result passes the cell stages and the total register before it is queued. Rows
// are kept in MAX_KERNEL banks of MAX_WIDTH bytes that need no clearing; the
// window is a chain of MAX_KERNEL column cells that shifts once per pixel.
// Program the registers only while no transaction is under way.
module conv2d_zero_pad_clamp_top #(
    parameter int MAX_WIDTH  = c2dzpc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = c2dzpc_pkg::MAX_KERNEL_DEF,
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [c2dzpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [c2dzpc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [7:0]                            i_pixel_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [7:0]                            o_pixel_out,
    output logic [c2dzpc_pkg::ROW_W-1:0]          o_out_row,
    output logic [COL_W-1:0]                      o_out_col,
    output logic                                  o_run_last
);

    localparam int SLOT_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int ROW_W    = c2dzpc_pkg::ROW_W;
    localparam int COLSUM_W = c2dzpc_pkg::PROD_W + $clog2(MAX_KERNEL);
    localparam int TOT_W    = COLSUM_W + $clog2(MAX_KERNEL);
    localparam int DEPTH    = c2dzpc_pkg::FIFO_DEPTH;
    localparam int CRED_W   = $clog2(DEPTH + 1);
    localparam int RES_W    = 1 + ROW_W + COL_W + 8;
    localparam int RECIP    = (1 << 15) / MAX_KERNEL;
    localparam int RST_W    = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RST_SLOT = 1023 % MAX_KERNEL;

    // ---------------------------------------------------------------
    // Configuration: decode each register into its effective form on write
    // ---------------------------------------------------------------
    logic [2:0]           r_k_eff;
    logic [1:0]           r_half;
    logic [COL_W-1:0]     r_w_last;
    logic [ROW_W-1:0]     r_h_last;
    logic [SLOT_W-1:0]    r_h_last_slot;
    logic [255:0]         r_coef;

    logic [2:0]           cfg_kcl;
    logic [2:0]           cfg_keff;
    logic [12:0]          cfg_wcl;
    logic [12:0]          cfg_hcl;
    logic [ROW_W-1:0]     cfg_hlast;
    logic [27:0]          cfg_prod;
    logic [15:0]          cfg_rem;

    always_comb begin
        cfg_kcl = (32'(i_cfg_data[2:0]) > MAX_KERNEL) ? 3'(MAX_KERNEL) : i_cfg_data[2:0];
        if (cfg_kcl[0]) begin
            cfg_keff = cfg_kcl;
        end else begin
            cfg_keff = (cfg_kcl == 3'd0) ? 3'd1 : cfg_kcl - 3'd1;
        end

        if (i_cfg_data[10:0] == 11'd0) begin
            cfg_wcl = 13'd1;
        end else if (32'(i_cfg_data[10:0]) > MAX_WIDTH) begin
            cfg_wcl = 13'(MAX_WIDTH);
        end else begin
            cfg_wcl = 13'(i_cfg_data[10:0]);
        end

        if (i_cfg_data[12:0] == 13'd0) begin
            cfg_hcl = 13'd1;
        end else if (32'(i_cfg_data[12:0]) > c2dzpc_pkg::MAX_HEIGHT) begin
            cfg_hcl = 13'(c2dzpc_pkg::MAX_HEIGHT);
        end else begin
            cfg_hcl = i_cfg_data[12:0];
        end
        cfg_hlast = ROW_W'(cfg_hcl - 13'd1);

        // Slot of the last row: reciprocal multiply, then one correction
        cfg_prod = 28'(cfg_hlast) * 28'(RECIP);
        cfg_rem  = 16'(cfg_hlast) - 16'(cfg_prod[27:15]) * 16'(MAX_KERNEL);
        if (cfg_rem >= 16'(MAX_KERNEL)) begin
            cfg_rem = cfg_rem - 16'(MAX_KERNEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_eff       <= 3'd3;
            r_half        <= 2'd1;
            r_w_last      <= COL_W'(RST_W - 1);
            r_h_last      <= ROW_W'(1023);
            r_h_last_slot <= SLOT_W'(RST_SLOT);
            r_coef        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                c2dzpc_pkg::CFG_KERNEL_SIZE: begin
                    r_k_eff <= cfg_keff;
                    r_half  <= 2'((cfg_keff - 3'd1) >> 1);
                end
                c2dzpc_pkg::CFG_IMAGE_WIDTH: begin
                    r_w_last <= COL_W'(cfg_wcl - 13'd1);
                end
                c2dzpc_pkg::CFG_IMAGE_HEIGHT: begin
                    r_h_last      <= cfg_hlast;
                    r_h_last_slot <= SLOT_W'(cfg_rem);
                end
                c2dzpc_pkg::CFG_COEFF_WORD_0: r_coef[63:0]    <= i_cfg_data;
                c2dzpc_pkg::CFG_COEFF_WORD_1: r_coef[127:64]  <= i_cfg_data;
                c2dzpc_pkg::CFG_COEFF_WORD_2: r_coef[191:128] <= i_cfg_data;
                c2dzpc_pkg::CFG_COEFF_WORD_3: r_coef[255:192] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input position: clamp against the frame, write the line store
    // ---------------------------------------------------------------
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col_cnt;
    logic [SLOT_W-1:0] r_slot;

    logic [ROW_W-1:0]  acc_row;
    logic [COL_W-1:0]  acc_col;
    logic [SLOT_W-1:0] acc_slot;
    logic              acc_last_row;
    logic              acc_last_col;
    logic              accept;

    always_comb begin
        acc_row      = (r_row > r_h_last) ? r_h_last : r_row;
        acc_slot     = (r_row > r_h_last) ? r_h_last_slot : r_slot;
        acc_col      = (r_col_cnt > r_w_last) ? r_w_last : r_col_cnt;
        acc_last_row = (acc_row == r_h_last);
        acc_last_col = (acc_col == r_w_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col_cnt <= '0;
            r_slot    <= '0;
        end else if (accept) begin
            if (acc_last_col) begin
                r_col_cnt <= '0;
                if (acc_last_row) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= acc_row + 1'b1;
                    r_slot <= (acc_slot == SLOT_W'(MAX_KERNEL - 1)) ? '0 : acc_slot + 1'b1;
                end
            end else begin
                r_col_cnt <= acc_col + 1'b1;
                r_row     <= acc_row;
                r_slot    <= acc_slot;
            end
        end
    end

    logic [MAX_KERNEL-1:0][7:0] lines_rd;

    c2dzpc_lines #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_lines (
        .i_clk  (i_clk),
        .i_we   (accept),
        .i_slot (acc_slot),
        .i_addr (acc_col),
        .i_data (i_pixel_in),
        .i_re   (accept),
        .o_data (lines_rd)
    );

    // ---------------------------------------------------------------
    // Column stage: pixel plus the stored rows above it
    // ---------------------------------------------------------------
    logic              r_s1_valid;
    logic [7:0]        r_s1_pix;
    logic [ROW_W-1:0]  r_s1_row;
    logic [COL_W-1:0]  r_s1_col;
    logic [SLOT_W-1:0] r_s1_slot;
    logic              r_s1_last_row;
    logic              r_s1_last_col;
    logic              s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= i_pixel_in;
            r_s1_row      <= acc_row;
            r_s1_col      <= acc_col;
            r_s1_slot     <= acc_slot;
            r_s1_last_row <= acc_last_row;
            r_s1_last_col <= acc_last_col;
        end
    end

    logic [MAX_KERNEL-1:0][7:0] new_col;
    logic [SLOT_W-1:0]          rd_slot [MAX_KERNEL];

    // Byte b of a column is row (r - b); rows above the frame read as zero
    always_comb begin
        for (int b = 0; b < MAX_KERNEL; b++) begin
            if (r_s1_slot >= SLOT_W'(b)) begin
                rd_slot[b] = r_s1_slot - SLOT_W'(b);
            end else begin
                rd_slot[b] = SLOT_W'(r_s1_slot + SLOT_W'(MAX_KERNEL - b));
            end
            if (b == 0) begin
                new_col[b] = r_s1_pix;
            end else if (r_s1_row >= ROW_W'(b)) begin
                new_col[b] = lines_rd[rd_slot[b]];
            end else begin
                new_col[b] = '0;
            end
        end
    end

    // Results this pixel completes: rows e_lo..e_hi, columns d_lo..d_hi
    logic [1:0]       s1_elo;
    logic [1:0]       s1_ehi;
    logic [1:0]       s1_dlo;
    logic [1:0]       s1_dhi;
    logic [ROW_W-1:0] s1_row_lo;
    logic [COL_W-1:0] s1_col_lo;
    logic             s1_row_short;
    logic             s1_col_short;
    logic             s1_has_jobs;

    always_comb begin
        s1_row_short = (r_s1_row < ROW_W'(r_half));
        s1_col_short = (r_s1_col < COL_W'(r_half));
        s1_elo    = s1_row_short ? r_half - r_s1_row[1:0] : 2'd0;
        s1_ehi    = r_s1_last_row ? r_half : 2'd0;
        s1_dlo    = s1_col_short ? r_half - r_s1_col[1:0] : 2'd0;
        s1_dhi    = r_s1_last_col ? r_half : 2'd0;
        s1_row_lo = s1_row_short ? '0 : r_s1_row - ROW_W'(r_half);
        s1_col_lo = s1_col_short ? '0 : r_s1_col - COL_W'(r_half);
        s1_has_jobs = (r_s1_last_row || !s1_row_short) && (r_s1_last_col || !s1_col_short);
    end

    // ---------------------------------------------------------------
    // Result sequencer: one window placement a cycle while the queue has room, row then column
    // ---------------------------------------------------------------
    logic              r_sq_valid;
    logic [1:0]        r_sq_e;
    logic [1:0]        r_sq_ehi;
    logic [1:0]        r_sq_d;
    logic [1:0]        r_sq_dlo;
    logic [1:0]        r_sq_dhi;
    logic [ROW_W-1:0]  r_sq_row;
    logic [COL_W-1:0]  r_sq_col;
    logic [COL_W-1:0]  r_sq_col_lo;
    logic [CRED_W-1:0] r_credit;
    logic              issue;
    logic              sq_last;
    logic              pop;

    assign issue   = r_sq_valid && (r_credit < CRED_W'(DEPTH));
    assign sq_last = (r_sq_e == r_sq_ehi) && (r_sq_d == r_sq_dhi);
    assign s1_adv  = r_s1_valid && (!r_sq_valid || (issue && sq_last));
    assign accept  = i_in_valid && (!r_s1_valid || s1_adv);
    assign o_in_stall = r_s1_valid && !s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
        end else if (s1_adv) begin
            r_sq_valid <= s1_has_jobs;
        end else if (issue && sq_last) begin
            r_sq_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_sq_e      <= s1_elo;
            r_sq_ehi    <= s1_ehi;
            r_sq_d      <= s1_dlo;
            r_sq_dlo    <= s1_dlo;
            r_sq_dhi    <= s1_dhi;
            r_sq_row    <= s1_row_lo;
            r_sq_col    <= s1_col_lo;
            r_sq_col_lo <= s1_col_lo;
        end else if (issue) begin
            if (r_sq_d == r_sq_dhi) begin
                r_sq_d   <= r_sq_dlo;
                r_sq_col <= r_sq_col_lo;
                r_sq_e   <= r_sq_e + 2'd1;
                r_sq_row <= r_sq_row + 1'b1;
            end else begin
                r_sq_d   <= r_sq_d + 2'd1;
                r_sq_col <= r_sq_col + 1'b1;
            end
        end
    end

    // Reserve a queue entry per issued result, free it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CRED_W'(issue) - CRED_W'(pop);
        end
    end

    c2dzpc_pkg::t_job job;

    assign job.d = r_sq_d;
    assign job.e = r_sq_e;
    assign job.k = r_k_eff;
    assign job.h = r_half;

    // ---------------------------------------------------------------
    // Cell chain: newest column in cell 0; a new row clears the rest
    // ---------------------------------------------------------------
    logic [MAX_KERNEL-1:0][7:0] chain_col [MAX_KERNEL];
    logic signed [COLSUM_W-1:0] cell_sum  [MAX_KERNEL];
    logic                       chain_clear;

    assign chain_clear = (r_s1_col == '0);

    for (genvar a = 0; a < MAX_KERNEL; a++) begin : g_cell
        c2dzpc_cell #(
            .MAX_KERNEL (MAX_KERNEL),
            .CELL_IDX   (a)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (s1_adv),
            .i_clear (chain_clear),
            .i_col   ((a == 0) ? new_col : chain_col[(a == 0) ? 0 : a - 1]),
            .o_col   (chain_col[a]),
            .i_job   (job),
            .i_coef  (r_coef),
            .o_sum   (cell_sum[a])
        );
    end

    // ---------------------------------------------------------------
    // Result tags ride alongside the three cell stages, then the total
    // ---------------------------------------------------------------
    logic [3:0]             r_pv;
    logic [ROW_W-1:0]       r_prow  [4];
    logic [COL_W-1:0]       r_pcol  [4];
    logic [3:0]             r_plast;
    logic signed [TOT_W-1:0] r_pd_sum;
    logic signed [TOT_W-1:0] n_pd_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            r_pv <= {r_pv[2:0], issue};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prow[0]  <= r_sq_row;
        r_pcol[0]  <= r_sq_col;
        r_plast[0] <= sq_last;
        for (int s = 1; s < 4; s++) begin
            r_prow[s]  <= r_prow[s-1];
            r_pcol[s]  <= r_pcol[s-1];
            r_plast[s] <= r_plast[s-1];
        end
        r_pd_sum <= n_pd_sum;
    end

    always_comb begin
        n_pd_sum = '0;
        for (int a = 0; a < MAX_KERNEL; a++) begin
            n_pd_sum = n_pd_sum + TOT_W'(cell_sum[a]);
        end
    end

    // Round half up at bit 7, clamp to 0..255
    logic signed [TOT_W:0]   rnd;
    logic signed [TOT_W-7:0] rnd_sh;
    logic [7:0]              res_pix;

    always_comb begin
        rnd    = (TOT_W + 1)'(r_pd_sum) + (TOT_W + 1)'(64);
        rnd_sh = rnd[TOT_W:7];
        if (rnd < 0) begin
            res_pix = 8'd0;
        end else if (rnd_sh > (TOT_W - 6)'(255)) begin
            res_pix = 8'd255;
        end else begin
            res_pix = rnd_sh[7:0];
        end
    end

    // ---------------------------------------------------------------
    // Result queue and output transaction
    // ---------------------------------------------------------------
    logic [RES_W-1:0] q_out;
    logic             q_empty;

    assign pop = o_out_valid && !i_out_stall;

    c2dzpc_fifo #(
        .DATA_W (RES_W),
        .DEPTH  (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_pv[3]),
        .i_data  ({r_plast[3], r_prow[3], r_pcol[3], res_pix}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    assign o_out_valid = !q_empty;
    assign o_run_last  = q_out[RES_W-1];
    assign o_out_row   = q_out[RES_W-2 -: ROW_W];
    assign o_out_col   = q_out[8 +: COL_W];
    assign o_pixel_out = q_out[7:0];

endmodule
